// ----- sv/lav_pkg.sv -----
// shared widths, row codes for the look-at view matrix block
// no dependencies; imported by lav_norm, lav_rows, look_at_view_matrix and the testbench
package lav_pkg;

  localparam int unsigned COORD_W = 32;  // q16.16 input coordinate
  localparam int unsigned AXIS_W  = 18;  // q2.16 unit component, -1.0 .. 1.0
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned NRM_W   = 30;  // scaled magnitude, top bit at 2^29
  localparam int unsigned SUM_W   = 62;  // sum of three squares
  localparam int unsigned ROOT_W  = 31;  // floor square root of the sum
  localparam int unsigned QUO_W   = 17;  // quotient magnitude, up to 1.0
  localparam int unsigned NUM_W   = 47;  // rounded dividend
  localparam int unsigned DIFF_W  = 33;  // eye minus target
  localparam int unsigned CROSS_W = 35;  // q32 cross product of two unit vectors

  typedef enum logic [1:0] {
    ROW_RIGHT = 2'd0,
    ROW_UP    = 2'd1,
    ROW_BACK  = 2'd2
  } row_e;

endpackage

// ----- sv/lav_norm.sv -----
// pipelined vector normalise: scale, squares, bit-pair square root, bit-pair division
// depends on lav_pkg
module lav_norm #(
  parameter int unsigned IN_W = 33,
  parameter int unsigned SB_W = 1
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  logic [2:0][IN_W-1:0]                   vec_i,
  input  logic [SB_W-1:0]                        sb_i,
  output logic                                   valid_o,
  output logic [2:0][lav_pkg::AXIS_W-1:0]        unit_o,
  output logic                                   zero_o,
  output logic [SB_W-1:0]                        sb_o
);
  import lav_pkg::*;

  localparam int unsigned MSB_W = $clog2(IN_W);
  localparam int unsigned SQR_W = 2 * NRM_W;
  localparam int unsigned SQT_W = SUM_W + 2;
  localparam int unsigned DVT_W = NUM_W + 1;
  localparam int unsigned SQ_ST = (ROOT_W + 1) / 2;
  localparam int unsigned DV_ST = (QUO_W + 1) / 2;

  typedef struct packed {
    logic                   zero;
    logic [2:0]             neg;
    logic [2:0][NRM_W-1:0]  nm;
    logic [SB_W-1:0]        sb;
  } car_t;

  typedef struct packed {
    logic [SUM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } dv_t;

  function automatic sq_t sq_step(sq_t a, int unsigned i);
    logic [SQT_W-1:0] t;
    sq_t              r;
    r = a;
    t = (SQT_W'(a.root) << (i + 1)) + (SQT_W'(1) << (2 * i));
    if (SQT_W'(a.rem) >= t) begin
      r.rem  = a.rem - SUM_W'(t);
      r.root = a.root | (ROOT_W'(1) << i);
    end
    return r;
  endfunction

  function automatic dv_t dv_step(dv_t a, logic [ROOT_W-1:0] len, int unsigned i);
    logic [DVT_W-1:0] t;
    dv_t              r;
    r = a;
    t = DVT_W'(len) << i;
    if (DVT_W'(a.rem) >= t) begin
      r.rem = a.rem - NUM_W'(t);
      r.quo = a.quo | (QUO_W'(1) << i);
    end
    return r;
  endfunction

  // stage 1: magnitudes and largest one
  logic                  s1_vld_q;
  logic [2:0][IN_W-1:0]  s1_mag_q, s1_mag_d;
  logic [2:0]            s1_neg_q, s1_neg_d;
  logic [IN_W-1:0]       s1_max_q, s1_max_d;
  logic [SB_W-1:0]       s1_sb_q;

  always_comb begin
    s1_max_d = '0;
    for (int k = 0; k < 3; k++) begin
      s1_neg_d[k] = vec_i[k][IN_W-1];
      s1_mag_d[k] = s1_neg_d[k] ? (~vec_i[k] + IN_W'(1)) : vec_i[k];
      if (s1_mag_d[k] > s1_max_d) begin
        s1_max_d = s1_mag_d[k];
      end
    end
  end

  // stage 2: scale so the largest magnitude has its top bit at 2^29
  logic                   s2_vld_q;
  logic [MSB_W-1:0]       msb;
  logic [2:0][NRM_W-1:0]  s2_nm_q, s2_nm_d;
  logic [2:0]             s2_neg_q;
  logic                   s2_zero_q;
  logic [SB_W-1:0]        s2_sb_q;

  always_comb begin
    msb = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (s1_max_q[i]) begin
        msb = MSB_W'(i);
      end
    end
    for (int k = 0; k < 3; k++) begin
      if (msb >= MSB_W'(NRM_W - 1)) begin
        s2_nm_d[k] = NRM_W'(s1_mag_q[k] >> (msb - MSB_W'(NRM_W - 1)));
      end else begin
        s2_nm_d[k] = NRM_W'(s1_mag_q[k] << (MSB_W'(NRM_W - 1) - msb));
      end
    end
  end

  // stage 3: squares
  logic                   s3_vld_q;
  logic [2:0][SQR_W-1:0]  s3_sq_q;
  car_t                   s3_car_q;

  // square root pipe, index 0 loaded with the sum
  logic sq_vld_q [SQ_ST+1];
  sq_t  sq_q     [SQ_ST+1];
  car_t sq_car_q [SQ_ST+1];

  // divide pipe, three lanes sharing the length
  logic              dv_vld_q [DV_ST+1];
  dv_t               dv_q     [DV_ST+1][3];
  car_t              dv_car_q [DV_ST+1];
  logic [ROOT_W-1:0] dv_len_q [DV_ST+1];

  logic                         out_vld_q;
  logic [2:0][AXIS_W-1:0]       out_unit_q;
  logic                         out_zero_q;
  logic [SB_W-1:0]              out_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      s3_vld_q    <= 1'b0;
      sq_vld_q[0] <= 1'b0;
      dv_vld_q[0] <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      s1_vld_q    <= valid_i;
      s2_vld_q    <= s1_vld_q;
      s3_vld_q    <= s2_vld_q;
      sq_vld_q[0] <= s3_vld_q;
      dv_vld_q[0] <= sq_vld_q[SQ_ST];
      out_vld_q   <= dv_vld_q[DV_ST];
    end
  end

  always_ff @(posedge clk_i) begin
    s1_mag_q  <= s1_mag_d;
    s1_neg_q  <= s1_neg_d;
    s1_max_q  <= s1_max_d;
    s1_sb_q   <= sb_i;

    s2_nm_q   <= s2_nm_d;
    s2_neg_q  <= s1_neg_q;
    s2_zero_q <= (s1_max_q == '0);
    s2_sb_q   <= s1_sb_q;

    for (int k = 0; k < 3; k++) begin
      s3_sq_q[k] <= s2_nm_q[k] * s2_nm_q[k];
    end
    s3_car_q <= '{zero: s2_zero_q, neg: s2_neg_q, nm: s2_nm_q, sb: s2_sb_q};

    sq_q[0].rem  <= SUM_W'(s3_sq_q[0]) + SUM_W'(s3_sq_q[1]) + SUM_W'(s3_sq_q[2]);
    sq_q[0].root <= '0;
    sq_car_q[0]  <= s3_car_q;

    // rounded dividend c * 65536 + len / 2
    for (int k = 0; k < 3; k++) begin
      dv_q[0][k].rem <= NUM_W'({sq_car_q[SQ_ST].nm[k], {FRAC_W{1'b0}}})
                        + NUM_W'(sq_q[SQ_ST].root >> 1);
      dv_q[0][k].quo <= '0;
    end
    dv_len_q[0] <= sq_q[SQ_ST].root;
    dv_car_q[0] <= sq_car_q[SQ_ST];

    for (int k = 0; k < 3; k++) begin
      if (dv_car_q[DV_ST].zero) begin
        out_unit_q[k] <= '0;
      end else if (dv_car_q[DV_ST].neg[k]) begin
        out_unit_q[k] <= ~AXIS_W'(dv_q[DV_ST][k].quo) + AXIS_W'(1);
      end else begin
        out_unit_q[k] <= AXIS_W'(dv_q[DV_ST][k].quo);
      end
    end
    out_zero_q <= dv_car_q[DV_ST].zero;
    out_sb_q   <= dv_car_q[DV_ST].sb;
  end

  for (genvar s = 0; s < SQ_ST; s++) begin : g_sq
    localparam int unsigned B0 = ROOT_W - 1 - 2 * s;
    sq_t nxt;
    if (B0 >= 1) begin : g_two
      assign nxt = sq_step(sq_step(sq_q[s], B0), B0 - 1);
    end else begin : g_one
      assign nxt = sq_step(sq_q[s], B0);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[s+1] <= 1'b0;
      end else begin
        sq_vld_q[s+1] <= sq_vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      sq_q[s+1]     <= nxt;
      sq_car_q[s+1] <= sq_car_q[s];
    end
  end

  for (genvar s = 0; s < DV_ST; s++) begin : g_dv
    localparam int unsigned B0 = QUO_W - 1 - 2 * s;
    dv_t nxt [3];
    for (genvar k = 0; k < 3; k++) begin : g_lane
      if (B0 >= 1) begin : g_two
        assign nxt[k] = dv_step(dv_step(dv_q[s][k], dv_len_q[s], B0), dv_len_q[s], B0 - 1);
      end else begin : g_one
        assign nxt[k] = dv_step(dv_q[s][k], dv_len_q[s], B0);
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[s+1] <= 1'b0;
      end else begin
        dv_vld_q[s+1] <= dv_vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      for (int k = 0; k < 3; k++) begin
        dv_q[s+1][k] <= nxt[k];
      end
      dv_len_q[s+1] <= dv_len_q[s];
      dv_car_q[s+1] <= dv_car_q[s];
    end
  end

  assign valid_o = out_vld_q;
  assign unit_o  = out_unit_q;
  assign zero_o  = out_zero_q;
  assign sb_o    = out_sb_q;

endmodule

// ----- sv/lav_rows.sv -----
// up axis by cross product, then row offsets as rounded, saturated minus dot with eye
// depends on lav_pkg
module lav_rows (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        valid_i,
  input  logic [2:0][lav_pkg::AXIS_W-1:0]             x_i,
  input  logic [2:0][lav_pkg::AXIS_W-1:0]             z_i,
  input  logic [2:0][lav_pkg::COORD_W-1:0]            eye_i,
  input  logic                                        degen_i,
  output logic                                        valid_o,
  output logic [2:0][2:0][lav_pkg::AXIS_W-1:0]        axis_o,
  output logic [2:0][lav_pkg::COORD_W-1:0]            offset_o,
  output logic                                        degen_o
);
  import lav_pkg::*;

  localparam int unsigned WD_W  = 52;
  localparam int unsigned PRD_W = AXIS_W + COORD_W;
  localparam int unsigned CY_W  = 2 * AXIS_W + 1;

  function automatic logic signed [WD_W-1:0] rnd_q32(logic signed [WD_W-1:0] v);
    logic [WD_W-1:0] m;
    m = v[WD_W-1] ? (~v + WD_W'(1)) : v;
    m = (m + WD_W'(32768)) >> FRAC_W;
    return v[WD_W-1] ? $signed(~m + WD_W'(1)) : $signed(m);
  endfunction

  // r1: raw q32 up axis
  logic                          r1_vld_q;
  logic signed [2:0][CY_W-1:0]   r1_cy_q;
  logic [2:0][AXIS_W-1:0]        r1_x_q, r1_z_q;
  logic [2:0][COORD_W-1:0]       r1_eye_q;
  logic                          r1_deg_q;

  // r2: rounded, clamped up axis
  logic                          r2_vld_q;
  logic [2:0][2:0][AXIS_W-1:0]   r2_ax_q;
  logic [2:0][COORD_W-1:0]       r2_eye_q;
  logic                          r2_deg_q;
  logic [2:0][AXIS_W-1:0]        y_d;

  // r3: dot product terms
  logic                               r3_vld_q;
  logic signed [2:0][2:0][PRD_W-1:0]  r3_p_q;
  logic [2:0][2:0][AXIS_W-1:0]        r3_ax_q;
  logic                               r3_deg_q;

  // r4: negated dot sums
  logic                               r4_vld_q;
  logic signed [2:0][WD_W-1:0]        r4_nd_q;
  logic [2:0][2:0][AXIS_W-1:0]        r4_ax_q;
  logic                               r4_deg_q;

  logic                               r5_vld_q;
  logic [2:0][COORD_W-1:0]            r5_off_q;
  logic [2:0][2:0][AXIS_W-1:0]        r5_ax_q;
  logic                               r5_deg_q;

  logic signed [WD_W-1:0] yr [3];
  logic signed [WD_W-1:0] offr [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      yr[k] = rnd_q32(WD_W'($signed(r1_cy_q[k])));
      if (yr[k] > WD_W'(65536)) begin
        y_d[k] = AXIS_W'(65536);
      end else if (yr[k] < -WD_W'(65536)) begin
        y_d[k] = AXIS_W'(-65536);
      end else begin
        y_d[k] = AXIS_W'(yr[k]);
      end
      offr[k] = rnd_q32(r4_nd_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_vld_q <= 1'b0;
      r2_vld_q <= 1'b0;
      r3_vld_q <= 1'b0;
      r4_vld_q <= 1'b0;
      r5_vld_q <= 1'b0;
    end else begin
      r1_vld_q <= valid_i;
      r2_vld_q <= r1_vld_q;
      r3_vld_q <= r2_vld_q;
      r4_vld_q <= r3_vld_q;
      r5_vld_q <= r4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r1_cy_q[0] <= CY_W'($signed(z_i[1]) * $signed(x_i[2]))
                - CY_W'($signed(z_i[2]) * $signed(x_i[1]));
    r1_cy_q[1] <= CY_W'($signed(z_i[2]) * $signed(x_i[0]))
                - CY_W'($signed(z_i[0]) * $signed(x_i[2]));
    r1_cy_q[2] <= CY_W'($signed(z_i[0]) * $signed(x_i[1]))
                - CY_W'($signed(z_i[1]) * $signed(x_i[0]));
    r1_x_q   <= x_i;
    r1_z_q   <= z_i;
    r1_eye_q <= eye_i;
    r1_deg_q <= degen_i;

    r2_ax_q[ROW_RIGHT] <= r1_x_q;
    r2_ax_q[ROW_UP]    <= y_d;
    r2_ax_q[ROW_BACK]  <= r1_z_q;
    r2_eye_q           <= r1_eye_q;
    r2_deg_q           <= r1_deg_q;

    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        r3_p_q[r][k] <= $signed(r2_ax_q[r][k]) * $signed(r2_eye_q[k]);
      end
    end
    r3_ax_q  <= r2_ax_q;
    r3_deg_q <= r2_deg_q;

    for (int r = 0; r < 3; r++) begin
      r4_nd_q[r] <= -(WD_W'($signed(r3_p_q[r][0])) + WD_W'($signed(r3_p_q[r][1]))
                      + WD_W'($signed(r3_p_q[r][2])));
    end
    r4_ax_q  <= r3_ax_q;
    r4_deg_q <= r3_deg_q;

    for (int r = 0; r < 3; r++) begin
      if (offr[r] > WD_W'(64'sd2147483647)) begin
        r5_off_q[r] <= 32'h7fff_ffff;
      end else if (offr[r] < -WD_W'(64'sd2147483648)) begin
        r5_off_q[r] <= 32'h8000_0000;
      end else begin
        r5_off_q[r] <= COORD_W'(offr[r]);
      end
    end
    r5_ax_q  <= r4_ax_q;
    r5_deg_q <= r4_deg_q;
  end

  assign valid_o  = r5_vld_q;
  assign axis_o   = r5_ax_q;
  assign offset_o = r5_off_q;
  assign degen_o  = r5_deg_q;

endmodule

// ----- sv/look_at_view_matrix.sv -----
// right-handed look-at view matrix, q16.16 fixed point, top level
// depends on lav_pkg, lav_norm, lav_rows
//
// usage
//   command channel: a beat is taken on a rising edge with start high and busy low;
//   it carries eye, target and world up, each a signed q16.16 vector
//   result channel: three beats per command, rows right, up, back in that order,
//   each shown for one cycle with strobe_o high; the receiver cannot hold them off
//   busy rises with each accepted beat and stays up until the busy counter has run down,
//   since the three rows share one result port; earlier commands keep moving meanwhile
//   a command passes the input register, the back and up normalise pipes side by side,
//   the cross product and the right normalise pipe, each normalise pipe a bit-pair
//   square root and a bit-pair division, then five row offset stages and the output
//   bank, whose first beat is the right row;
//   every stage advances each cycle with a valid bit beside its data, so commands
//   in flight never collide and nothing waits on the output
//   reset clears all valid bits and the busy counter; data registers are not reset
module look_at_view_matrix (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [31:0]          eye_x_i,
  input  logic signed [31:0]          eye_y_i,
  input  logic signed [31:0]          eye_z_i,
  input  logic signed [31:0]          target_x_i,
  input  logic signed [31:0]          target_y_i,
  input  logic signed [31:0]          target_z_i,
  input  logic signed [31:0]          up_x_i,
  input  logic signed [31:0]          up_y_i,
  input  logic signed [31:0]          up_z_i,
  output logic                        strobe_o,
  output logic signed [17:0]          axis_x_o,
  output logic signed [17:0]          axis_y_o,
  output logic signed [17:0]          axis_z_o,
  output logic signed [31:0]          offset_o,
  output logic [1:0]                  row_o,
  output logic                        last_o,
  output logic                        degenerate_o
);
  import lav_pkg::*;

  localparam int unsigned XSB_W = 3 * AXIS_W + 3 * COORD_W + 1;

  // busy window: spaces accepted commands so their row beats do not overlap
  logic [1:0] busy_cnt_q;
  logic       accept;

  assign busy   = (busy_cnt_q != 2'd0);
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_cnt_q <= 2'd0;
    end else if (accept) begin
      busy_cnt_q <= 2'd2;
    end else if (busy) begin
      busy_cnt_q <= busy_cnt_q - 2'd1;
    end
  end

  // input register: view direction as an exact 33-bit difference
  logic                       in_vld_q;
  logic [2:0][DIFF_W-1:0]     d_q;
  logic [2:0][COORD_W-1:0]    up_q;
  logic [2:0][COORD_W-1:0]    eye_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q[0]   <= {eye_x_i[31], eye_x_i} - {target_x_i[31], target_x_i};
    d_q[1]   <= {eye_y_i[31], eye_y_i} - {target_y_i[31], target_y_i};
    d_q[2]   <= {eye_z_i[31], eye_z_i} - {target_z_i[31], target_z_i};
    up_q     <= {up_z_i, up_y_i, up_x_i};
    eye_q    <= {eye_z_i, eye_y_i, eye_x_i};
  end

  // back axis and normalised up run side by side with equal latency;
  // the eye rides along split over the two sideband buses
  logic                          z_vld, u_vld;
  logic [2:0][AXIS_W-1:0]        z_unit, u_unit;
  logic                          z_zero, u_zero;
  logic [2*COORD_W-1:0]          z_sb;
  logic [COORD_W-1:0]            u_sb;

  lav_norm #(
    .IN_W (DIFF_W),
    .SB_W (2 * COORD_W)
  ) u_norm_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld_q),
    .vec_i   (d_q),
    .sb_i    ({eye_q[2], eye_q[1]}),
    .valid_o (z_vld),
    .unit_o  (z_unit),
    .zero_o  (z_zero),
    .sb_o    (z_sb)
  );

  lav_norm #(
    .IN_W (COORD_W),
    .SB_W (COORD_W)
  ) u_norm_u (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_vld_q),
    .vec_i   (up_q),
    .sb_i    (eye_q[0]),
    .valid_o (u_vld),
    .unit_o  (u_unit),
    .zero_o  (u_zero),
    .sb_o    (u_sb)
  );

  // cross(up, back) exact in q32
  logic                         c_vld_q;
  logic [2:0][CROSS_W-1:0]      c_q;
  logic [2:0][AXIS_W-1:0]       cz_q;
  logic [2:0][COORD_W-1:0]      ceye_q;
  logic                         cdeg_q;
  logic signed [2*AXIS_W:0]     cx_d [3];

  always_comb begin
    cx_d[0] = (2*AXIS_W+1)'($signed(u_unit[1]) * $signed(z_unit[2]))
            - (2*AXIS_W+1)'($signed(u_unit[2]) * $signed(z_unit[1]));
    cx_d[1] = (2*AXIS_W+1)'($signed(u_unit[2]) * $signed(z_unit[0]))
            - (2*AXIS_W+1)'($signed(u_unit[0]) * $signed(z_unit[2]));
    cx_d[2] = (2*AXIS_W+1)'($signed(u_unit[0]) * $signed(z_unit[1]))
            - (2*AXIS_W+1)'($signed(u_unit[1]) * $signed(z_unit[0]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= z_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      c_q[k] <= cx_d[k][CROSS_W-1:0];
    end
    cz_q   <= z_unit;
    ceye_q <= {z_sb, u_sb};
    cdeg_q <= z_zero || u_zero;
  end

  // right axis
  logic                          x_vld;
  logic [2:0][AXIS_W-1:0]        x_unit;
  logic                          x_zero;
  logic [XSB_W-1:0]              x_sb;

  lav_norm #(
    .IN_W (CROSS_W),
    .SB_W (XSB_W)
  ) u_norm_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_vld_q),
    .vec_i   (c_q),
    .sb_i    ({cz_q, ceye_q, cdeg_q}),
    .valid_o (x_vld),
    .unit_o  (x_unit),
    .zero_o  (x_zero),
    .sb_o    (x_sb)
  );

  // sideband split back out: back axis, eye, earlier degenerate flag
  logic [2:0][AXIS_W-1:0]   xz;
  logic [2:0][COORD_W-1:0]  xeye;
  logic                     xdeg;

  assign {xz, xeye, xdeg} = x_sb;

  logic                              rows_vld;
  logic [2:0][2:0][AXIS_W-1:0]       rows_ax;
  logic [2:0][COORD_W-1:0]           rows_off;
  logic                              rows_deg;

  lav_rows u_rows (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (x_vld),
    .x_i      (x_unit),
    .z_i      (xz),
    .eye_i    (xeye),
    .degen_i  (xdeg || x_zero),
    .valid_o  (rows_vld),
    .axis_o   (rows_ax),
    .offset_o (rows_off),
    .degen_o  (rows_deg)
  );

  // result serialiser: a finished matrix lands in the bank and goes out as three
  // beats; the next matrix can arrive no earlier than the cycle of the back row
  logic                            str_q;
  row_e                            row_q;
  logic [2:0][2:0][AXIS_W-1:0]     bank_ax_q;
  logic [2:0][COORD_W-1:0]         bank_off_q;
  logic                            bank_deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      str_q <= 1'b0;
      row_q <= ROW_RIGHT;
    end else if (rows_vld) begin
      str_q <= 1'b1;
      row_q <= ROW_RIGHT;
    end else if (str_q) begin
      case (row_q)
        ROW_RIGHT: row_q <= ROW_UP;
        ROW_UP:    row_q <= ROW_BACK;
        default: begin
          str_q <= 1'b0;
          row_q <= ROW_RIGHT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rows_vld) begin
      bank_ax_q  <= rows_ax;
      bank_off_q <= rows_off;
      bank_deg_q <= rows_deg;
    end
  end

  assign strobe_o     = str_q;
  assign axis_x_o     = bank_ax_q[row_q][0];
  assign axis_y_o     = bank_ax_q[row_q][1];
  assign axis_z_o     = bank_ax_q[row_q][2];
  assign offset_o     = bank_off_q[row_q];
  assign row_o        = row_q;
  assign last_o       = (row_q == ROW_BACK);
  assign degenerate_o = bank_deg_q;

  // the two parallel normalise pipes must stay in lockstep
  assert property (@(posedge clk_i) disable iff (!rst_ni) u_vld == z_vld)
    else $error("normalise pipes out of step");

  // a new matrix may only land on the back-row beat or when idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rows_vld |-> (!str_q || row_q == ROW_BACK))
    else $error("matrix arrived while rows still pending");

  // the right row is always followed by the up row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && row_q == ROW_RIGHT) |=> (strobe_o && row_q == ROW_UP))
    else $error("row sequence broken");

  // an accepted command closes the window for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // degenerate flag is a per-matrix value, steady over its three beats
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && row_q != ROW_RIGHT) |-> $stable(degenerate_o))
    else $error("degenerate flag changed within a matrix");

endmodule

// ----- sim/tb.sv -----
// testbench for look_at_view_matrix: random and directed look-at commands
// depends on lav_pkg and the look_at_view_matrix rtl; predicts every row beat itself
`timescale 1ns / 1ps

module tb;
  import lav_pkg::*;

  // one row of the expected view matrix
  typedef struct {
    logic signed [17:0] ax;
    logic signed [17:0] ay;
    logic signed [17:0] az;
    logic signed [31:0] off;
    row_e               row;
    logic               last;
    logic               degen;
  } row_beat_t;

  // one look-at command
  typedef struct {
    logic signed [31:0] eye [3];
    logic signed [31:0] tgt [3];
    logic signed [31:0] up  [3];
  } view_cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] eye_x_i = '0, eye_y_i = '0, eye_z_i = '0;
  logic signed [31:0] target_x_i = '0, target_y_i = '0, target_z_i = '0;
  logic signed [31:0] up_x_i = '0, up_y_i = '0, up_z_i = '0;
  logic strobe_o;
  logic signed [17:0] axis_x_o, axis_y_o, axis_z_o;
  logic signed [31:0] offset_o;
  logic [1:0] row_o;
  logic last_o, degenerate_o;

  view_cmd_t pending_cmds[$];
  row_beat_t expected_rows[$];
  int  errors = 0;
  int  gap_pct = 31;   // sender idle chance, percent
  bit  taken = 1'b0;   // beat taken at the last rising edge

  look_at_view_matrix dut (.*);

  // clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  // q32 to q16.16, half away from zero
  function automatic longint round_q32(longint v);
    longint unsigned m;
    m = (mag(v) + 64'd32768) >> 16;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // unit vector in q16.16; returns 0 on zero length
  function automatic bit unit_vec(input longint v [3], output longint u [3]);
    longint unsigned m [3];
    longint unsigned mx, sum, len, q;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      u = '{0, 0, 0};
      return 1'b0;
    end
    // bring the largest magnitude into [2^29, 2^30)
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 64'd65536 + len / 2) / len;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > 65536) return 65536;
    if (v < -65536) return -65536;
    return v;
  endfunction

  // queue the three row beats a command must produce
  task automatic predict_view_rows(view_cmd_t c);
    longint eye [3], d [3], upv [3], u [3], zb [3], cr [3], xr [3], yu [3], a [3];
    longint dot, off;
    bit ok;
    row_beat_t b;
    for (int i = 0; i < 3; i++) begin
      eye[i] = c.eye[i];
      d[i] = longint'(c.eye[i]) - longint'(c.tgt[i]);
      upv[i] = c.up[i];
    end
    ok = unit_vec(d, zb);
    ok = unit_vec(upv, u) & ok;
    cr[0] = u[1] * zb[2] - u[2] * zb[1];
    cr[1] = u[2] * zb[0] - u[0] * zb[2];
    cr[2] = u[0] * zb[1] - u[1] * zb[0];
    ok = unit_vec(cr, xr) & ok;
    yu[0] = clamp_unit(round_q32(zb[1] * xr[2] - zb[2] * xr[1]));
    yu[1] = clamp_unit(round_q32(zb[2] * xr[0] - zb[0] * xr[2]));
    yu[2] = clamp_unit(round_q32(zb[0] * xr[1] - zb[1] * xr[0]));
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        a[i] = (k == 0) ? xr[i] : (k == 1) ? yu[i] : zb[i];
      end
      dot = a[0] * eye[0] + a[1] * eye[1] + a[2] * eye[2];
      off = round_q32(-dot);
      if (off > 64'sd2147483647) off = 64'sd2147483647;
      if (off < -64'sd2147483648) off = -64'sd2147483648;
      b.ax = a[0][17:0];
      b.ay = a[1][17:0];
      b.az = a[2][17:0];
      b.off = off[31:0];
      b.row = (k == 0) ? ROW_RIGHT : (k == 1) ? ROW_UP : ROW_BACK;
      b.last = (k == 2);
      b.degen = !ok;
      expected_rows.push_back(b);
    end
  endtask

  // ---------------------------------------------------------------- driver

  // inputs move on the falling edge; a beat is held until taken at a rising edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!start || taken) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= gap_pct) begin
          drive_cmd(pending_cmds.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic drive_cmd(view_cmd_t c);
    eye_x_i    <= c.eye[0];
    eye_y_i    <= c.eye[1];
    eye_z_i    <= c.eye[2];
    target_x_i <= c.tgt[0];
    target_y_i <= c.tgt[1];
    target_z_i <= c.tgt[2];
    up_x_i     <= c.up[0];
    up_y_i     <= c.up[1];
    up_z_i     <= c.up[2];
    start      <= 1'b1;
  endtask

  // prediction at acceptance, so the expected order follows the accepted order
  always @(posedge clk_i) begin
    view_cmd_t c;
    taken = rst_ni && start && !busy;
    if (taken) begin
      c.eye = '{eye_x_i, eye_y_i, eye_z_i};
      c.tgt = '{target_x_i, target_y_i, target_z_i};
      c.up  = '{up_x_i, up_y_i, up_z_i};
      predict_view_rows(c);
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk_i) begin
    row_beat_t e;
    if (rst_ni && strobe_o) begin
      if (expected_rows.size() == 0) begin
        $error("row beat with nothing expected: row %0d", row_o);
        errors++;
      end else begin
        e = expected_rows.pop_front();
        if (axis_x_o !== e.ax) begin
          $error("axis_x expected %0d actual %0d", e.ax, axis_x_o);
          errors++;
        end
        if (axis_y_o !== e.ay) begin
          $error("axis_y expected %0d actual %0d", e.ay, axis_y_o);
          errors++;
        end
        if (axis_z_o !== e.az) begin
          $error("axis_z expected %0d actual %0d", e.az, axis_z_o);
          errors++;
        end
        if (offset_o !== e.off) begin
          $error("offset expected %0d actual %0d", e.off, offset_o);
          errors++;
        end
        if (row_o !== e.row) begin
          $error("row expected %0d actual %0d", e.row, row_o);
          errors++;
        end
        if (last_o !== e.last) begin
          $error("last expected %0d actual %0d", e.last, last_o);
          errors++;
        end
        if (degenerate_o !== e.degen) begin
          $error("degenerate expected %0d actual %0d", e.degen, degenerate_o);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0:       return $urandom;                              // full range
      1:       return $signed($urandom_range(8191)) - 4096;  // tiny
      2:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(32'h01ffffff)) - 32'sh01000000;
    endcase
  endfunction

  function automatic view_cmd_t rand_cmd();
    view_cmd_t c;
    int pick;
    for (int i = 0; i < 3; i++) begin
      c.eye[i] = rand_coord();
      c.tgt[i] = rand_coord();
      c.up[i]  = rand_coord();
    end
    pick = $urandom_range(19);
    if (pick == 0) c.tgt = c.eye;                  // eye on target
    else if (pick == 1) c.up = '{0, 0, 0};         // zero up
    else if (pick == 2) begin                      // up along the view line
      for (int i = 0; i < 3; i++) c.up[i] = c.eye[i] - c.tgt[i];
    end else if (pick < 8) begin                   // usual camera: up is +y
      c.up = '{0, 32'sh00010000, 0};
    end
    return c;
  endfunction

  function automatic view_cmd_t mk_cmd(logic signed [31:0] ex, ey, ez, tx, ty, tz,
                                       ux, uy, uz);
    view_cmd_t c;
    c.eye = '{ex, ey, ez};
    c.tgt = '{tx, ty, tz};
    c.up  = '{ux, uy, uz};
    return c;
  endfunction

  task automatic add_phase(int n);
    for (int i = 0; i < n; i++) pending_cmds.push_back(rand_cmd());
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || start || expected_rows.size() > 0)
      @(posedge clk_i);
  endtask

  localparam logic signed [31:0] ONE  = 32'sh00010000;
  localparam logic signed [31:0] MAXC = 32'sh7fffffff;
  localparam logic signed [31:0] MINC = 32'sh80000000;

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: plain camera, extremes, saturated offsets and degenerate cases
    pending_cmds.push_back(mk_cmd(0, 0, 3 * ONE, 0, 0, 0, 0, ONE, 0));
    pending_cmds.push_back(mk_cmd(ONE, 2 * ONE, 5 * ONE, 0, 0, 0, 0, ONE, 0));
    pending_cmds.push_back(mk_cmd(MAXC, MAXC, MAXC, MINC, MINC, MINC, 0, ONE, 0));
    pending_cmds.push_back(mk_cmd(MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MINC, 1));
    pending_cmds.push_back(mk_cmd(MAXC, MINC, MAXC, 0, 0, 0, MINC, MAXC, MINC));
    pending_cmds.push_back(mk_cmd(MAXC, MAXC, MAXC, MAXC - 1, MAXC, MAXC, 0, 0, 1));
    pending_cmds.push_back(mk_cmd(5, 5, 5, 5, 5, 5, 0, ONE, 0));           // eye on target
    pending_cmds.push_back(mk_cmd(ONE, 0, 0, 0, 0, 0, 0, 0, 0));           // zero up
    pending_cmds.push_back(mk_cmd(0, 4 * ONE, 0, 0, 0, 0, 0, ONE, 0));     // up parallel
    pending_cmds.push_back(mk_cmd(0, -4 * ONE, 0, 0, 0, 0, 0, ONE, 0));    // antiparallel
    pending_cmds.push_back(mk_cmd(1, 0, 0, 0, 0, 0, 0, 1, 0));             // lsb vectors
    pending_cmds.push_back(mk_cmd(-1, -1, -1, 0, 0, 0, -1, -1, 1));
    pending_cmds.push_back(mk_cmd(0, 0, 0, 0, 0, 0, 0, 0, 0));             // all zero
    pending_cmds.push_back(mk_cmd(32'sh5555aaaa, 32'shaaaa5555, 32'sh0f0f0f0f,
                                  32'shf0f0f0f0, 32'sh33333333, 32'shcccccccc,
                                  32'sh12345678, 32'shedcba987, 32'sh7f00ff01));
    pending_cmds.push_back(mk_cmd(MINC, 0, 0, MAXC, 0, 0, MAXC, MAXC, MAXC));
    add_phase(150);
    wait_drained();

    gap_pct = 78;
    add_phase(170);
    wait_drained();

    gap_pct = 0;
    add_phase(170);
    wait_drained();

    // let anything still in the pipe surface
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
sv/lav_pkg.sv
sv/lav_norm.sv
sv/lav_rows.sv
sv/look_at_view_matrix.sv
sim/tb.sv
